// File: hw/rtl/pdhl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdhl_pkg
// Shared types and constants of the debounced port history log.
// ----------------------------------------------------------------------------
package pdhl_pkg;

  localparam int unsigned PortWidth    = 8;
  localparam int unsigned HistDepth    = 16;
  localparam int unsigned HistIdxW     = $clog2(HistDepth);
  localparam int unsigned TicksW       = 8;
  localparam int unsigned KindW        = 2;
  localparam logic [TicksW-1:0] DebounceReset = TicksW'(50);
  localparam logic [TicksW-1:0] CountMax      = '1;

  typedef enum logic [KindW-1:0] {
    KindChange = 2'd0,
    KindTick   = 2'd1,
    KindRead   = 2'd2,
    KindLoad   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [PortWidth-1:0] pins;
    logic [HistIdxW-1:0]  slot;
  } item_t;

  typedef struct packed {
    logic                 saved;
    logic [PortWidth-1:0] saved_value;
    logic [HistIdxW-1:0]  next_slot;
    logic                 pending;
    logic [PortWidth-1:0] read_value;
  } result_t;

endpackage

// File: hw/rtl/pdhl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdhl channel interfaces
// Valid/ready channels for items, results and the debounce register write.
// ----------------------------------------------------------------------------
interface pdhl_in_if;
  logic                              valid;
  logic                              ready;
  logic [pdhl_pkg::KindW-1:0]        kind;
  logic [pdhl_pkg::PortWidth-1:0]    pins;
  logic [pdhl_pkg::HistIdxW-1:0]     slot;
  modport source (output valid, kind, pins, slot, input ready);
  modport sink   (input valid, kind, pins, slot, output ready);
endinterface

interface pdhl_out_if;
  logic                              valid;
  logic                              ready;
  logic                              saved;
  logic [pdhl_pkg::PortWidth-1:0]    saved_value;
  logic [pdhl_pkg::HistIdxW-1:0]     next_slot;
  logic                              pending;
  logic [pdhl_pkg::PortWidth-1:0]    read_value;
  modport source (output valid, saved, saved_value, next_slot, pending, read_value,
                  input ready);
  modport sink   (input valid, saved, saved_value, next_slot, pending, read_value,
                  output ready);
endinterface

interface pdhl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pdhl_pkg::TicksW-1:0]       data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/pdhl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdhl_core
// Debounce window state, history ring and the per-beat result logic.
// ----------------------------------------------------------------------------
module pdhl_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  pdhl_pkg::item_t               item_i,
  input  logic [pdhl_pkg::TicksW-1:0]   ticks_i,
  output pdhl_pkg::result_t             result_o
);

  logic [pdhl_pkg::PortWidth-1:0] hist_q [pdhl_pkg::HistDepth];
  logic [pdhl_pkg::HistIdxW-1:0]  wp_q, wp_d;
  logic                           active_q, active_d;
  logic [pdhl_pkg::TicksW-1:0]    count_q, count_d;
  logic [pdhl_pkg::PortWidth-1:0] cand_q, cand_d;
  logic [pdhl_pkg::PortWidth-1:0] stable_q, stable_d;
  logic [pdhl_pkg::TicksW-1:0]    count_inc;
  logic                           hist_we;
  logic [pdhl_pkg::PortWidth-1:0] read_value;

  assign count_inc = (count_q == pdhl_pkg::CountMax) ? count_q : count_q + 1'b1;

  always_comb begin
    wp_d       = wp_q;
    active_d   = active_q;
    count_d    = count_q;
    cand_d     = cand_q;
    stable_d   = stable_q;
    hist_we    = 1'b0;
    read_value = '0;
    case (item_i.kind)
      pdhl_pkg::KindChange: begin
        if (!active_q) begin
          active_d = 1'b1;
          count_d  = '0;
          cand_d   = item_i.pins;
        end
      end
      pdhl_pkg::KindTick: begin
        if (active_q) begin
          if (item_i.pins == cand_q) begin
            if (count_inc >= ticks_i) begin
              if (item_i.pins != stable_q) begin
                hist_we  = 1'b1;
                wp_d     = (wp_q == pdhl_pkg::HistIdxW'(pdhl_pkg::HistDepth - 1)) ?
                           '0 : wp_q + 1'b1;
                stable_d = item_i.pins;
              end
              active_d = 1'b0;
              count_d  = '0;
            end else begin
              count_d = count_inc;
            end
          end else begin
            cand_d  = item_i.pins;
            count_d = '0;
          end
        end
      end
      pdhl_pkg::KindRead: begin
        read_value = hist_q[item_i.slot];
      end
      pdhl_pkg::KindLoad: begin
        stable_d = item_i.pins;
      end
      default: begin
        stable_d = stable_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pdhl_pkg::HistDepth; i++) begin
        hist_q[i] <= '0;
      end
      wp_q     <= '0;
      active_q <= 1'b0;
      count_q  <= '0;
      cand_q   <= '0;
      stable_q <= '0;
    end else if (step_i) begin
      if (hist_we) begin
        hist_q[wp_q] <= item_i.pins;
      end
      wp_q     <= wp_d;
      active_q <= active_d;
      count_q  <= count_d;
      cand_q   <= cand_d;
      stable_q <= stable_d;
    end
  end

  always_comb begin
    result_o.saved       = hist_we;
    result_o.saved_value = hist_we ? item_i.pins : '0;
    result_o.next_slot   = wp_d;
    result_o.pending     = active_d;
    result_o.read_value  = read_value;
  end

endmodule

// File: hw/rtl/port_debounce_history_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_debounce_history_log
// Debounces an eight-bit port and logs each new stable level in a 16-entry ring.
// an item's result is loaded into the result register as it leaves the input register while out is free
// throughput: one item per cycle while out is not stalled, set by the single-pass update of the window state
// an input register and a result register sit on either side of the update logic
// reset clears the ring, window state, write position and sets debounce_ticks to 50
// ----------------------------------------------------------------------------
module port_debounce_history_log (
  input  logic         clk_i,
  input  logic         rst_ni,
  pdhl_in_if.sink      in_i,
  pdhl_out_if.source   out_o,
  pdhl_cfg_if.sink     cfg_i
);

  logic                        in_valid_q;
  pdhl_pkg::item_t             in_q;
  logic                        out_valid_q;
  pdhl_pkg::result_t           out_q;
  pdhl_pkg::result_t           result;
  logic [pdhl_pkg::TicksW-1:0] ticks_q;
  logic                        advance;
  logic                        in_ready;

  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready  = !in_valid_q || advance;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= pdhl_pkg::DebounceReset;
    end else if (cfg_i.valid) begin
      ticks_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q.kind <= pdhl_pkg::kind_e'(in_i.kind);
      in_q.pins <= in_i.pins;
      in_q.slot <= in_i.slot;
    end
  end

  pdhl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .ticks_i  (ticks_q),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.saved       = out_q.saved;
  assign out_o.saved_value = out_q.saved_value;
  assign out_o.next_slot   = out_q.next_slot;
  assign out_o.pending     = out_q.pending;
  assign out_o.read_value  = out_q.read_value;

endmodule

// File: hw/rtl/pdhl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdhl_checker
// Port-level checks of the result stream of the debounced port history log.
// ----------------------------------------------------------------------------
module pdhl_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                saved_i,
  input logic [pdhl_pkg::PortWidth-1:0]      saved_value_i,
  input logic [pdhl_pkg::HistIdxW-1:0]       next_slot_i,
  input logic                                pending_i,
  input logic [pdhl_pkg::PortWidth-1:0]      read_value_i
);

  logic                          out_acc;
  logic [pdhl_pkg::HistIdxW-1:0] last_slot_q;
  logic                          last_pending_q;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_slot_q    <= '0;
      last_pending_q <= 1'b0;
    end else if (out_acc) begin
      last_slot_q    <= next_slot_i;
      last_pending_q <= pending_i;
    end
  end

  // ring position moves by one exactly on a saved beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && saved_i |-> next_slot_i == last_slot_q + 1'b1)
    else $error("next_slot did not advance on a saved beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !saved_i |-> next_slot_i == last_slot_q)
    else $error("next_slot moved without a saved beat");

  // a save needs an open window before it and closes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && saved_i |-> last_pending_q && !pending_i && read_value_i == '0)
    else $error("saved beat without a preceding open window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(saved_i) &&
      $stable(saved_value_i) && $stable(next_slot_i) && $stable(pending_i) &&
      $stable(read_value_i))
    else $error("stalled result beat changed");

endmodule

bind port_debounce_history_log pdhl_checker u_pdhl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .saved_i       (out_o.saved),
  .saved_value_i (out_o.saved_value),
  .next_slot_i   (out_o.next_slot),
  .pending_i     (out_o.pending),
  .read_value_i  (out_o.read_value)
);
